>>> src/irce_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ir command frame encoder
// no dependencies

package irce_pkg;

   // frame preamble sent ahead of a command byte
   localparam logic [7:0] PREAMBLE_0 = 8'h55;
   localparam logic [7:0] PREAMBLE_1 = 8'hFF;
   localparam logic [7:0] PREAMBLE_2 = 8'h00;

   // position of an output byte within the sequence one payload byte causes
   typedef logic [2:0] step_type;

   localparam step_type STEP_PRE0     = 3'd0;
   localparam step_type STEP_PRE1     = 3'd1;
   localparam step_type STEP_PRE2     = 3'd2;
   localparam step_type STEP_DATA     = 3'd3;
   localparam step_type STEP_DATA_INV = 3'd4;
   localparam step_type STEP_SUM      = 3'd5;
   localparam step_type STEP_SUM_INV  = 3'd6;

endpackage

>>> src/ir_command_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ir command frame encoder: payload bytes in, framed transmit bytes out
// depends on irce_pkg
//
//   channel | dir | tdata              | tuser          | tlast
//   --------+-----+--------------------+----------------+-----------
//   req_    | in  | [7:0] payload_byte | [0] first_byte | last_byte
//   rsp_    | out | [7:0] frame_byte   | [0] frame_end  | run_last
//
// one frame byte leaves per cycle while rsp_tready holds high; an item gives 2
// frame bytes, 5 with a preamble, plus 2 with a checksum, through the single output register
// the item register takes the next item in the cycle its final byte moves
// into the output register, so the link stays busy across items
// reset (synchronous, active high) clears the running sum and both valids
// a stall on rsp_tready holds the output byte and the item register

module ir_command_frame_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] payload_byte
   input  logic [0:0] req_tuser,   // [0] first_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_byte
   output logic [0:0] rsp_tuser,   // [0] frame_end
   output logic       rsp_tlast    // run_last
);

   // running payload sum of the frame under way
   logic [7:0] running_sum_ff, running_sum_in;

   // item register: the byte being expanded and where we are in its sequence
   logic                 item_valid_ff, item_valid_in;
   logic [7:0]           item_byte_ff, item_byte_in;
   logic                 item_last_ff, item_last_in;
   logic [7:0]           item_sum_ff, item_sum_in;
   irce_pkg::step_type   item_step_ff, item_step_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       out_last_ff, out_last_in;

   logic               req_xfer;
   logic               out_load;
   logic               item_final;
   irce_pkg::step_type final_step;
   logic [7:0]         sum_next;
   logic [7:0]         step_byte;

   // output register can take a new byte when empty or being drained
   assign out_load   = !out_valid_ff || rsp_tready;
   assign final_step = item_last_ff ? irce_pkg::STEP_SUM_INV : irce_pkg::STEP_DATA_INV;
   // the item's last byte moves out this cycle
   assign item_final = item_valid_ff && out_load && (item_step_ff == final_step);

   assign req_tready = !item_valid_ff || item_final;
   assign req_xfer   = req_tvalid && req_tready;

   // a first byte restarts the sum
   assign sum_next = req_tuser[0] ? req_tdata : 8'(running_sum_ff + req_tdata);

   // byte for the current step of the held item
   always_comb begin
      unique case (item_step_ff)
         irce_pkg::STEP_PRE0:     step_byte = irce_pkg::PREAMBLE_0;
         irce_pkg::STEP_PRE1:     step_byte = irce_pkg::PREAMBLE_1;
         irce_pkg::STEP_PRE2:     step_byte = irce_pkg::PREAMBLE_2;
         irce_pkg::STEP_DATA:     step_byte = item_byte_ff;
         irce_pkg::STEP_DATA_INV: step_byte = ~item_byte_ff;
         irce_pkg::STEP_SUM:      step_byte = item_sum_ff;
         irce_pkg::STEP_SUM_INV:  step_byte = ~item_sum_ff;
         default:                 step_byte = item_byte_ff;
      endcase
   end

   always_comb begin
      running_sum_in = running_sum_ff;
      item_valid_in  = item_valid_ff;
      item_byte_in   = item_byte_ff;
      item_last_in   = item_last_ff;
      item_sum_in    = item_sum_ff;
      item_step_in   = item_step_ff;
      out_valid_in   = out_valid_ff;
      out_byte_in    = out_byte_ff;
      out_end_in     = out_end_ff;
      out_last_in    = out_last_ff;

      // advance the held item into the output register
      if (out_load) begin
         out_valid_in = item_valid_ff;
         out_byte_in  = step_byte;
         out_end_in   = (item_step_ff == irce_pkg::STEP_SUM_INV);
         out_last_in  = (item_step_ff == final_step);
         if (item_valid_ff) begin
            item_step_in = irce_pkg::step_type'(item_step_ff + 3'd1);
         end
         if (item_final) begin
            item_valid_in = 1'b0;
         end
      end

      // take a new item; the sum is settled at accept time
      if (req_xfer) begin
         item_valid_in  = 1'b1;
         item_byte_in   = req_tdata;
         item_last_in   = req_tlast;
         item_sum_in    = sum_next;
         item_step_in   = req_tuser[0] ? irce_pkg::STEP_PRE0 : irce_pkg::STEP_DATA;
         running_sum_in = req_tlast ? 8'h00 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= 8'h00;
         item_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         running_sum_ff <= running_sum_in;
         item_valid_ff  <= item_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_last_ff <= item_last_in;
      item_sum_ff  <= item_sum_in;
      item_step_ff <= item_step_in;
      out_byte_ff  <= out_byte_in;
      out_end_ff   <= out_end_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tuser[0] = out_end_ff;
   assign rsp_tlast    = out_last_ff;

`ifndef SYNTH
   // frame end is always the last byte of its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without run last");

   // held item never steps past the checksum complement
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> item_step_ff <= irce_pkg::STEP_SUM_INV)
      else $error("item step out of range");

   // a last byte closes the frame and clears the sum
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> running_sum_ff == 8'h00)
      else $error("running sum not cleared after last byte");

   // a first byte starts at the preamble
   a_first_preamble: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=>
         item_valid_ff && item_step_ff == irce_pkg::STEP_PRE0)
      else $error("first byte did not start with preamble");
`endif

endmodule
